@@ rtl/two_server_route_assignment_assert.svh @@
// ----------------------------------------------------------------------------
// two_server_route_assignment_assert.svh
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef TWO_SERVER_ROUTE_ASSIGNMENT_ASSERT_SVH
`define TWO_SERVER_ROUTE_ASSIGNMENT_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define TSRA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, quiet during reset
`define TSRA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/tsra_pkg.sv @@
// ----------------------------------------------------------------------------
// tsra_pkg
// shared codes, widths and types of the two-server route assignment block
// ----------------------------------------------------------------------------
package tsra_pkg;

    // fixed port widths
    localparam int GRID_W     = 10;
    localparam int COORD_IN_W = 10;
    localparam int IDX_IN_W   = 8;
    localparam int COST_OUT_W = 20;

    localparam logic [GRID_W-1:0]     GRID_RESET = 10'd1023;
    localparam logic [COST_OUT_W-1:0] COST_SAT   = 20'hFFFFF;

    // command codes
    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_SOLVE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    // solve sequencer states
    typedef enum logic [9:0] {
        S_IDLE    = 10'b0000000001,
        S_ROW0    = 10'b0000000010,
        S_ROW1    = 10'b0000000100,
        S_ROW2    = 10'b0000001000,
        S_ISSUE   = 10'b0000010000,
        S_CALC    = 10'b0000100000,
        S_WRITE   = 10'b0001000000,
        S_WALK_RD = 10'b0010000000,
        S_WALK_WR = 10'b0100000000,
        S_DONE    = 10'b1000000000
    } solve_state_t;

endpackage

@@ rtl/tsra_ram.sv @@
// ----------------------------------------------------------------------------
// tsra_ram
// simple dual-port ram, one write port, one read port with registered data
// ----------------------------------------------------------------------------
module tsra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/tsra_solver.sv @@
// ----------------------------------------------------------------------------
// tsra_solver
// fills the cost table row by row from the last request down, then walks
// the best path from both start corners and writes each request's server
// ----------------------------------------------------------------------------
module tsra_solver
    import tsra_pkg::*;
#(
    parameter int MAX_REQUESTS = 256,
    parameter int COORD_BITS   = 10
) (
    input  logic                                                   clk,
    input  logic                                                   rst_n,
    input  logic                                                   go,
    input  logic [$clog2(MAX_REQUESTS+1)-1:0]                      count,
    input  logic [GRID_W-1:0]                                      grid,
    output logic [((MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1)-1:0] pt_raddr,
    input  logic [2*COORD_BITS-1:0]                                pt_rdata,
    output logic                                                   asg_we,
    output logic [((MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1)-1:0] asg_waddr,
    output logic                                                   asg_wdata,
    output logic                                                   done,
    output logic [((COORD_BITS > GRID_W) ? COORD_BITS : GRID_W) + 1
                  + $clog2(MAX_REQUESTS+1):0]                      cost
);

    localparam int IDX_W  = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int CNT_W  = $clog2(MAX_REQUESTS + 1);
    localparam int PW     = (COORD_BITS > GRID_W) ? COORD_BITS : GRID_W;
    localparam int COST_W = PW + 2 + CNT_W;
    localparam int TBL_D  = 1 << (2 * IDX_W);

    solve_state_t state_reg, state_next;

    logic [CNT_W-1:0]  n_reg, n_next;
    logic [CNT_W-1:0]  m_reg, m_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic              half_reg, half_next;
    logic [CNT_W-1:0]  a_reg, a_next;
    logic [CNT_W-1:0]  b_reg, b_next;
    logic [PW-1:0]     pnx_reg, pny_reg, pmx_reg, pmy_reg;
    logic [COST_W-1:0] ca_reg, cb_reg, c1_reg, c2_reg, cost_reg;

    logic              tbl_we;
    logic [2*IDX_W-1:0] tbl_waddr, tbl_raddr;
    logic [COST_W:0]   tbl_wdata, tbl_rdata;
    logic [COST_W-1:0] rd_cost;
    logic              last_row;
    logic [PW-1:0]     rx, ry, g_ext, ax, ay, bx, by;
    logic [COST_W-1:0] cost_a, cost_b;
    logic              second;
    logic [CNT_W-1:0]  walk_max, walk_nxt;

    // table address of entry (a,b)
    function automatic logic [2*IDX_W-1:0] taddr(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        return {a[IDX_W-1:0], b[IDX_W-1:0]};
    endfunction

    // manhattan distance
    function automatic logic [PW:0] mdist(input logic [PW-1:0] px, input logic [PW-1:0] py,
                                          input logic [PW-1:0] qx, input logic [PW-1:0] qy);
        logic [PW-1:0] dx, dy;
        dx = (px > qx) ? (px - qx) : (qx - px);
        dy = (py > qy) ? (py - qy) : (qy - py);
        return {1'b0, dx} + {1'b0, dy};
    endfunction

    // cost and choice table, choice in the top bit
    tsra_ram #(
        .WIDTH (COST_W + 1),
        .DEPTH (TBL_D)
    ) u_tbl (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    assign last_row = ((m_reg + CNT_W'(1)) == n_reg);
    assign rd_cost  = last_row ? '0 : tbl_rdata[COST_W-1:0];
    assign rx       = PW'(pt_rdata[2*COORD_BITS-1:COORD_BITS]);
    assign ry       = PW'(pt_rdata[COORD_BITS-1:0]);
    assign g_ext    = PW'(grid);
    assign walk_max = (a_reg > b_reg) ? a_reg : b_reg;
    assign walk_nxt = walk_max + CNT_W'(1);

    // server positions and follow-on costs of the entry in work
    always_comb
    begin
        if (!half_reg)
        begin
            ax     = (k_reg == '0) ? PW'(1) : rx;
            ay     = (k_reg == '0) ? PW'(1) : ry;
            bx     = (m_reg == '0) ? g_ext : pmx_reg;
            by     = (m_reg == '0) ? g_ext : pmy_reg;
            cost_a = ca_reg;
            cost_b = rd_cost;
        end
        else
        begin
            ax     = (m_reg == '0) ? PW'(1) : pmx_reg;
            ay     = (m_reg == '0) ? PW'(1) : pmy_reg;
            bx     = (k_reg == '0) ? g_ext : rx;
            by     = (k_reg == '0) ? g_ext : ry;
            cost_a = rd_cost;
            cost_b = cb_reg;
        end
    end

    assign second    = !(c1_reg < c2_reg);
    assign tbl_we    = (state_reg == S_WRITE);
    assign tbl_waddr = half_reg ? taddr(m_reg, k_reg) : taddr(k_reg, m_reg);
    assign tbl_wdata = {second, second ? c2_reg : c1_reg};

    // read addresses per state
    always_comb
    begin
        pt_raddr  = k_reg[IDX_W-1:0] - IDX_W'(1);
        tbl_raddr = taddr(a_reg, b_reg);
        unique case (state_reg)
            S_ROW0:
            begin
                pt_raddr  = m_reg[IDX_W-1:0];
                tbl_raddr = taddr(m_reg + CNT_W'(1), m_reg);
            end
            S_ROW1:
            begin
                pt_raddr  = m_reg[IDX_W-1:0] - IDX_W'(1);
                tbl_raddr = taddr(m_reg, m_reg + CNT_W'(1));
            end
            S_ISSUE:
            begin
                tbl_raddr = half_reg ? taddr(m_reg + CNT_W'(1), k_reg)
                                     : taddr(k_reg, m_reg + CNT_W'(1));
            end
            default:
            begin
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        m_next     = m_reg;
        k_next     = k_reg;
        half_next  = half_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (go)
                begin
                    n_next     = count;
                    m_next     = count - CNT_W'(1);
                    a_next     = '0;
                    b_next     = '0;
                    state_next = (count == '0) ? S_DONE : S_ROW0;
                end
            end
            S_ROW0:  state_next = S_ROW1;
            S_ROW1:  state_next = S_ROW2;
            S_ROW2:
            begin
                k_next     = '0;
                half_next  = 1'b0;
                state_next = S_ISSUE;
            end
            S_ISSUE: state_next = S_CALC;
            S_CALC:  state_next = S_WRITE;
            S_WRITE:
            begin
                state_next = S_ISSUE;
                if (!half_reg)
                begin
                    if (k_reg == m_reg)
                    begin
                        k_next    = '0;
                        half_next = 1'b1;
                        if (m_reg == '0)
                        begin
                            state_next = S_WALK_RD;
                        end
                    end
                    else
                    begin
                        k_next = k_reg + CNT_W'(1);
                    end
                end
                else if (k_reg == m_reg - CNT_W'(1))
                begin
                    m_next     = m_reg - CNT_W'(1);
                    state_next = S_ROW0;
                end
                else
                begin
                    k_next = k_reg + CNT_W'(1);
                end
            end
            S_WALK_RD: state_next = S_WALK_WR;
            S_WALK_WR:
            begin
                if (tbl_rdata[COST_W])
                begin
                    b_next = walk_nxt;
                end
                else
                begin
                    a_next = walk_nxt;
                end
                state_next = (walk_nxt == n_reg) ? S_DONE : S_WALK_RD;
            end
            S_DONE:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            n_reg     <= '0;
            m_reg     <= '0;
            k_reg     <= '0;
            half_reg  <= 1'b0;
            a_reg     <= '0;
            b_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            m_reg     <= m_next;
            k_reg     <= k_next;
            half_reg  <= half_next;
            a_reg     <= a_next;
            b_reg     <= b_next;
        end
    end

    // row and entry data
    always_ff @(posedge clk)
    begin
        if (state_reg == S_ROW1)
        begin
            pnx_reg <= rx;
            pny_reg <= ry;
            ca_reg  <= rd_cost;
        end
        if (state_reg == S_ROW2)
        begin
            pmx_reg <= rx;
            pmy_reg <= ry;
            cb_reg  <= rd_cost;
        end
        if (state_reg == S_CALC)
        begin
            c1_reg <= cost_a + COST_W'(mdist(ax, ay, pnx_reg, pny_reg));
            c2_reg <= cost_b + COST_W'(mdist(bx, by, pnx_reg, pny_reg));
        end
        if (state_reg == S_IDLE)
        begin
            cost_reg <= '0;
        end
        else if (state_reg == S_WALK_WR && a_reg == '0 && b_reg == '0)
        begin
            cost_reg <= tbl_rdata[COST_W-1:0];
        end
    end

    // assignment write during the walk
    assign asg_we    = (state_reg == S_WALK_WR);
    assign asg_waddr = walk_max[IDX_W-1:0];
    assign asg_wdata = tbl_rdata[COST_W];

    assign done = (state_reg == S_DONE);
    assign cost = cost_reg;

endmodule

@@ rtl/two_server_route_assignment.sv @@
// ----------------------------------------------------------------------------
// two_server_route_assignment
// loads request points, solves the two-server assignment by dynamic
// programming over a cost table in ram, and reads back each request's server
// ----------------------------------------------------------------------------
//  channel   | signals                                  | handshake
//  ----------+------------------------------------------+----------------------
//  command   | cmd, x_coord, y_coord, event_index       | start high, busy low
//  result    | total_cost, server_choice, status        | done, one cycle
//  config    | cfg_data (grid_size)                     | cfg_valid, cfg_ready
//
//  load and read take one command beat per cycle while busy is low; the result
//  shows in the cycle after the command. a solve holds busy through the row
//  states ROW0, ROW1 and ROW2, the ISSUE, CALC and WRITE states of each table
//  entry (set by the single cost table port), the WALK_RD and WALK_WR states of
//  each walk step and the result beat. cfg_ready is low while a solve runs.
//  rst_n clears the request count and the solved flag; the ram contents are
//  not cleared. results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module two_server_route_assignment
    import tsra_pkg::*;
#(
    parameter int MAX_REQUESTS = 256,
    parameter int COORD_BITS   = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            cmd,
    input  logic [COORD_IN_W-1:0] x_coord,
    input  logic [COORD_IN_W-1:0] y_coord,
    input  logic [IDX_IN_W-1:0]   event_index,
    output logic                  done,
    output logic [COST_OUT_W-1:0] total_cost,
    output logic                  server_choice,
    output logic [1:0]            status,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [GRID_W-1:0]     cfg_data
);

    localparam int IDX_W  = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int CNT_W  = $clog2(MAX_REQUESTS + 1);
    localparam int PW     = (COORD_BITS > GRID_W) ? COORD_BITS : GRID_W;
    localparam int COST_W = PW + 2 + CNT_W;
    localparam int SAT_W  = (COST_W > COST_OUT_W) ? COST_W : COST_OUT_W;

    logic [GRID_W-1:0] grid_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              solved_reg;
    logic              busy_reg;
    logic              pend_reg;
    logic              pend_rd_reg;
    logic [1:0]        pend_status_reg;

    logic              accept, full, s_go, s_done;
    logic              pt_we, idx_ok, asg_we, asg_wdata, asg_rdata;
    logic [IDX_W-1:0]  pt_raddr, asg_waddr;
    logic [2*COORD_BITS-1:0] pt_wdata, pt_rdata;
    logic [PW-1:0]     x_ext, y_ext;
    logic [15:0]       idx_w, cnt_w;
    logic [COST_W-1:0] s_cost;
    logic [SAT_W-1:0]  c_ext;

    assign accept = start && !busy_reg;
    assign full   = (count_reg >= CNT_W'(MAX_REQUESTS));
    assign s_go   = accept && (cmd == CMD_SOLVE);
    assign pt_we  = accept && (cmd == CMD_LOAD) && !full;
    assign x_ext  = PW'(x_coord);
    assign y_ext  = PW'(y_coord);
    assign pt_wdata = {x_ext[COORD_BITS-1:0], y_ext[COORD_BITS-1:0]};
    assign idx_w  = 16'(event_index);
    assign cnt_w  = 16'(count_reg);
    assign idx_ok = solved_reg && (idx_w < cnt_w);

    // request point store
    tsra_ram #(
        .WIDTH (2 * COORD_BITS),
        .DEPTH (MAX_REQUESTS)
    ) u_pts (
        .clk   (clk),
        .we    (pt_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (pt_wdata),
        .raddr (pt_raddr),
        .rdata (pt_rdata)
    );

    // per-request server choice store
    tsra_ram #(
        .WIDTH (1),
        .DEPTH (MAX_REQUESTS)
    ) u_asg (
        .clk   (clk),
        .we    (asg_we),
        .waddr (asg_waddr),
        .wdata (asg_wdata),
        .raddr (idx_w[IDX_W-1:0]),
        .rdata (asg_rdata)
    );

    tsra_solver #(
        .MAX_REQUESTS (MAX_REQUESTS),
        .COORD_BITS   (COORD_BITS)
    ) u_solver (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (s_go),
        .count     (count_reg),
        .grid      (grid_reg),
        .pt_raddr  (pt_raddr),
        .pt_rdata  (pt_rdata),
        .asg_we    (asg_we),
        .asg_waddr (asg_waddr),
        .asg_wdata (asg_wdata),
        .done      (s_done),
        .cost      (s_cost)
    );

    // command handling and result staging
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_reg        <= GRID_RESET;
            count_reg       <= '0;
            solved_reg      <= 1'b0;
            busy_reg        <= 1'b0;
            pend_reg        <= 1'b0;
            pend_rd_reg     <= 1'b0;
            pend_status_reg <= ST_OK;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                grid_reg <= cfg_data;
            end
            pend_reg    <= 1'b0;
            pend_rd_reg <= 1'b0;
            if (s_done)
            begin
                busy_reg   <= 1'b0;
                solved_reg <= 1'b1;
            end
            if (accept)
            begin
                pend_status_reg <= ST_OK;
                unique case (cmd)
                    CMD_LOAD:
                    begin
                        pend_reg <= 1'b1;
                        if (full)
                        begin
                            pend_status_reg <= ST_FULL;
                        end
                        else
                        begin
                            count_reg  <= count_reg + CNT_W'(1);
                            solved_reg <= 1'b0;
                        end
                    end
                    CMD_SOLVE:
                    begin
                        busy_reg <= 1'b1;
                    end
                    CMD_READ:
                    begin
                        pend_reg    <= 1'b1;
                        pend_rd_reg <= idx_ok;
                        if (!idx_ok)
                        begin
                            pend_status_reg <= ST_BAD;
                        end
                    end
                    default:
                    begin
                        pend_reg <= 1'b1;
                    end
                endcase
            end
        end
    end

    // result beat
    assign c_ext         = SAT_W'(s_cost);
    assign done          = pend_reg || s_done;
    assign total_cost    = !s_done ? '0
                         : (c_ext > SAT_W'(COST_SAT)) ? COST_SAT : c_ext[COST_OUT_W-1:0];
    assign server_choice = pend_rd_reg && asg_rdata;
    assign status        = pend_reg ? pend_status_reg : ST_OK;
    assign busy          = busy_reg;
    assign cfg_ready     = !busy_reg;

endmodule

@@ rtl/tsra_checker.sv @@
// ----------------------------------------------------------------------------
// tsra_checker
// port-level checks on the two-server route assignment block
// ----------------------------------------------------------------------------
`include "two_server_route_assignment_assert.svh"

module tsra_checker
    import tsra_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  start,
    input logic                  busy,
    input logic [1:0]            cmd,
    input logic                  done,
    input logic [COST_OUT_W-1:0] total_cost,
    input logic                  server_choice,
    input logic [1:0]            status
);

    // a solve beat raises busy
    `TSRA_ASSERT_NXT(a_solve_busy, start && !busy && cmd == CMD_SOLVE, busy, "solve not busy")

    // an error result carries no cost
    `TSRA_ASSERT_IMP(a_err_nocost, done && status != ST_OK, total_cost == '0, "cost on error")

    // a server choice only shows on a good result beat
    `TSRA_ASSERT_IMP(a_choice_ok, server_choice, done && status == ST_OK, "stray choice")

    // busy drops only after the solve result beat
    `TSRA_ASSERT_IMP(a_busy_fall, $fell(busy), $past(done), "busy fell without result")

endmodule

bind two_server_route_assignment tsra_checker u_tsra_checker (.*);
